>>> src/idle_framed_packet_crc_receiver_top_assert.svh
// Assertion macros shared by the idle-framed packet receiver.
`ifndef IDLE_FRAMED_PACKET_CRC_RECEIVER_TOP_ASSERT_SVH
`define IDLE_FRAMED_PACKET_CRC_RECEIVER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IFPCR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IFPCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ifpcr_pkg.sv
// Shared types and constants of the idle-framed packet receiver.
`timescale 1ns / 1ps

package ifpcr_pkg;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_ACK  = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef struct packed {
    logic clr;
    logic feed;
  } crc_ctl_t;

  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd20;

endpackage

>>> src/ifpcr_store.sv
// Packet byte store: one write port and one registered read port.
`timescale 1ns / 1ps

module ifpcr_store #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/ifpcr_crc.sv
// CRC-16/XMODEM accumulator that takes one byte per cycle while feed is asserted.
`timescale 1ns / 1ps

module ifpcr_crc (
  input  logic                clk,
  input  logic                rst_n,
  input  ifpcr_pkg::crc_ctl_t ctl,
  input  logic [7:0]          data,
  output logic [15:0]         crc
);

  import ifpcr_pkg::*;

  logic [15:0] crc_r;

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] x;
    x = c ^ {d, 8'h00};
    for (int b = 0; b < 8; b++) begin
      x = x[15] ? ((x << 1) ^ CRC_POLY) : (x << 1);
    end
    return x;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
    end else if (ctl.clr) begin
      crc_r <= '0;
    end else if (ctl.feed) begin
      crc_r <= crc_step(crc_r, data);
    end
  end

  assign crc = crc_r;

endmodule

>>> src/idle_framed_packet_crc_receiver_top.sv
// Top level of the idle-framed packet receiver with CRC-16/XMODEM check.
// Byte, tick and acknowledge go from idle to S_FIN; an entry read passes S_READ first.
// A tick that closes a frame of L bytes walks the store in S_CRC, then S_CHECK (no S_CRC when L <= 2).
// One item at a time: a new item is taken only in S_IDLE, after S_FIN has handed off the result.
// Synchronous reset clears state, counters and flags, not the entry, close or walk registers;
// the store is not swept, a fill count marks its written entries so unwritten ones read as zero.
`timescale 1ns / 1ps

module idle_framed_packet_crc_receiver_top #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // rx_byte[7:0], entry_index[14:8], zero[15]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // entry_data[7:0], packet_length[14:8], frame_closed[15], data_available[16],
  // crc_ok[17], calculated_crc[33:18], received_crc[49:34],
  // read_incomplete[50], crc_error_count[82:51], zero[87:83]
  output logic [87:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  import ifpcr_pkg::*;

  localparam int PW = $clog2(BUFFER_DEPTH);
  localparam int FW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [PW-1:0] POS_LAST = PW'(BUFFER_DEPTH - 1);
  localparam logic [8:0]    DEPTH_W  = 9'(BUFFER_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CRC,
    S_CHECK,
    S_FIN
  } state_t;

  state_t        state_r;
  logic [15:0]   timeout_r;
  logic [PW-1:0] wp_r;
  logic [FW-1:0] fill_r;
  logic          armed_r;
  logic [15:0]   idle_cnt_r;
  logic          err_r;
  logic          avail_r;
  logic          ack_r;
  logic          crc_ok_r;
  logic [15:0]   calc_r;
  logic [15:0]   recv_r;
  logic [31:0]   miss_cnt_r;
  logic [7:0]    entry_r;
  logic          entry_ok_r;
  logic          closed_r;
  logic [PW-1:0] ra_r;
  logic [PW-1:0] ri_r;
  logic          rv_r;
  logic          iss_done_r;
  logic [15:0]   rx_crc_r;
  logic          out_valid_r;
  logic [87:0]   out_tdata_r;

  op_t           in_op;
  logic [7:0]    in_byte;
  logic [6:0]    in_idx;
  logic          in_acc;
  logic          tick_close;
  logic [PW-1:0] wp_nxt;
  logic [FW-1:0] fill_nxt;
  logic          mem_we;
  logic [PW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  crc_ctl_t      crc_ctl;
  logic [15:0]   crc_val;

  assign in_op   = op_t'(in_tuser);
  assign in_byte = in_tdata[7:0];
  assign in_idx  = in_tdata[14:8];
  assign in_acc  = in_tvalid && in_tready;

  assign tick_close = armed_r && (idle_cnt_r >= timeout_r) && (wp_r != '0);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  assign wp_nxt   = (wp_r == POS_LAST) ? '0 : wp_r + PW'(1);
  assign fill_nxt = FW'(wp_r) + FW'(1);

  assign mem_we    = in_acc && (in_op == OP_BYTE) && !err_r;
  assign mem_raddr = (state_r == S_CRC) ? ra_r : PW'(in_idx);

  assign crc_ctl.clr  = in_acc;
  assign crc_ctl.feed = (state_r == S_CRC) && rv_r && (ri_r < wp_r - PW'(2));

  ifpcr_store #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (PW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wp_r),
    .wr_data (in_byte),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  ifpcr_crc u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (crc_ctl),
    .data  (mem_rdata),
    .crc   (crc_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      timeout_r   <= TIMEOUT_RESET;
      wp_r        <= '0;
      fill_r      <= '0;
      armed_r     <= 1'b0;
      idle_cnt_r  <= '0;
      err_r       <= 1'b0;
      avail_r     <= 1'b0;
      ack_r       <= 1'b0;
      crc_ok_r    <= 1'b0;
      calc_r      <= '0;
      recv_r      <= '0;
      miss_cnt_r  <= '0;
      rv_r        <= 1'b0;
      iss_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (out_valid_r && out_tready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            entry_r    <= '0;
            closed_r   <= (in_op == OP_TICK) && tick_close;
            entry_ok_r <= ({2'b00, in_idx} < DEPTH_W) && ({2'b00, in_idx} < 9'(fill_r));
            case (in_op)
              OP_BYTE: begin
                if (!err_r) begin
                  wp_r <= wp_nxt;
                  if (fill_nxt > fill_r) begin
                    fill_r <= fill_nxt;
                  end
                end
                idle_cnt_r <= '0;
                armed_r    <= 1'b1;
                state_r    <= S_FIN;
              end
              OP_TICK: begin
                if (tick_close) begin
                  armed_r    <= 1'b0;
                  rx_crc_r   <= '0;
                  ra_r       <= '0;
                  rv_r       <= 1'b0;
                  iss_done_r <= 1'b0;
                  if (!ack_r) begin
                    err_r <= 1'b1;
                  end
                  state_r <= (wp_r > PW'(2)) ? S_CRC : S_CHECK;
                end else begin
                  state_r <= S_FIN;
                  if (armed_r) begin
                    if (idle_cnt_r >= timeout_r) begin
                      armed_r <= 1'b0;
                    end else begin
                      idle_cnt_r <= idle_cnt_r + 16'd1;
                    end
                  end
                end
              end
              OP_ACK: begin
                wp_r    <= '0;
                fill_r  <= '0;
                avail_r <= 1'b0;
                ack_r   <= 1'b1;
                err_r   <= 1'b0;
                state_r <= S_FIN;
              end
              OP_READ: begin
                state_r <= S_READ;
              end
              default: begin
                state_r <= S_FIN;
              end
            endcase
          end
        end
        S_READ: begin
          entry_r <= entry_ok_r ? mem_rdata : 8'd0;
          state_r <= S_FIN;
        end
        S_CRC: begin
          rv_r <= !iss_done_r;
          ri_r <= ra_r;
          if (!iss_done_r) begin
            if (ra_r == wp_r - PW'(1)) begin
              iss_done_r <= 1'b1;
            end else begin
              ra_r <= ra_r + PW'(1);
            end
          end
          if (rv_r) begin
            if (ri_r == wp_r - PW'(2)) begin
              rx_crc_r[15:8] <= mem_rdata;
            end
            if (ri_r == wp_r - PW'(1)) begin
              rx_crc_r[7:0] <= mem_rdata;
              state_r       <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          calc_r <= crc_val;
          recv_r <= rx_crc_r;
          ack_r  <= 1'b0;
          if (crc_val == rx_crc_r) begin
            crc_ok_r <= 1'b1;
            avail_r  <= 1'b1;
          end else begin
            crc_ok_r   <= 1'b0;
            avail_r    <= 1'b0;
            miss_cnt_r <= miss_cnt_r + 32'd1;
            wp_r       <= '0;
            fill_r     <= '0;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_tdata_r <= {5'b00000, miss_cnt_r, err_r, recv_r, calc_r, crc_ok_r,
                            avail_r, closed_r, 7'(wp_r), entry_r};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`include "idle_framed_packet_crc_receiver_top_assert.svh"

  `IFPCR_ASSERT_NOW(a_fill_covers_pos, clk, rst_n, wp_r != '0,
                    FW'(wp_r) <= fill_r, "write position beyond fill count")
  `IFPCR_ASSERT_NEXT(a_drop_on_error, clk, rst_n, in_acc && (in_op == OP_BYTE) && err_r,
                     wp_r == $past(wp_r), "byte stored while error latched")
  `IFPCR_ASSERT_NOW(a_avail_needs_match, clk, rst_n, avail_r,
                    crc_ok_r, "packet available without CRC match")

endmodule

>>> sim/tb_idle_framed_packet_crc_receiver_top.sv
// Self-checking regression of the idle-framed packet receiver against a built-in predictor.
`timescale 1ns / 1ps

module tb_idle_framed_packet_crc_receiver_top;
  import ifpcr_pkg::*;

  localparam int DEPTH = 128;
  localparam int TARGET_ITEMS = 1950;
  localparam int SETTLE_CYCLES = 150;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [4:0]  pad;
    logic [31:0] crc_errors;
    logic        read_incomplete;
    logic [15:0] received_crc;
    logic [15:0] calculated_crc;
    logic        crc_ok;
    logic        data_available;
    logic        frame_closed;
    logic [6:0]  packet_length;
    logic [7:0]  entry_data;
  } status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  logic [7:0]  pkt_mem [DEPTH];
  logic [6:0]  wr_pos;
  logic        idle_armed;
  logic        err_latched;
  logic        avail;
  logic        host_acked;
  logic        crc_match;
  logic [15:0] idle_cnt;
  logic [15:0] idle_limit;
  logic [15:0] calc_crc;
  logic [15:0] recv_crc;
  logic [31:0] mismatch_cnt;

  status_t     pending_status[$];
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int          burst_left = 0;
  logic [9:0]  stall_phase = '0;
  logic [15:0] stall_pattern = 16'b1011_0010_1110_0101;

  idle_framed_packet_crc_receiver_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("idle_framed_packet_crc_receiver_top regression: fail");
    $finish;
  end

  function automatic logic [15:0] crc16_xmodem(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    int b;
    c = crc ^ {data, 8'h00};
    for (b = 0; b < 8; b++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic void clear_packet();
    foreach (pkt_mem[i]) pkt_mem[i] = '0;
    wr_pos = '0;
  endfunction

  function automatic void reset_receiver_model();
    clear_packet();
    idle_limit = TIMEOUT_RESET;
    idle_armed = 1'b0;
    idle_cnt = '0;
    err_latched = 1'b0;
    avail = 1'b0;
    host_acked = 1'b0;
    crc_match = 1'b0;
    calc_crc = '0;
    recv_crc = '0;
    mismatch_cnt = '0;
  endfunction

  function automatic logic close_frame();
    logic [15:0] calc;
    logic [15:0] recv;
    int len;
    int i;
    idle_armed = 1'b0;
    if (wr_pos == 0) return 1'b0;
    if (!host_acked) err_latched = 1'b1;
    calc = '0;
    recv = '0;
    len = wr_pos;
    if (len > 2) begin
      for (i = 0; i < len - 2; i++) calc = crc16_xmodem(calc, pkt_mem[i]);
      recv = {pkt_mem[len - 2], pkt_mem[len - 1]};
    end
    calc_crc = calc;
    recv_crc = recv;
    crc_match = (calc == recv);
    if (crc_match) begin
      avail = 1'b1;
    end else begin
      mismatch_cnt = mismatch_cnt + 1;
      clear_packet();
      avail = 1'b0;
    end
    host_acked = 1'b0;
    return 1'b1;
  endfunction

  function automatic status_t predict_status(op_t op, logic [7:0] data_byte,
                                             logic [6:0] index);
    status_t s;
    s = '0;
    case (op)
      OP_BYTE: begin
        if (!err_latched) begin
          pkt_mem[wr_pos] = data_byte;
          wr_pos = wr_pos + 1'b1;
        end
        idle_cnt = '0;
        idle_armed = 1'b1;
      end
      OP_TICK: begin
        if (idle_armed) begin
          if (idle_cnt >= idle_limit) s.frame_closed = close_frame();
          else idle_cnt = idle_cnt + 1'b1;
        end
      end
      OP_ACK: begin
        clear_packet();
        avail = 1'b0;
        host_acked = 1'b1;
        err_latched = 1'b0;
      end
      default: begin
        s.entry_data = pkt_mem[index];
      end
    endcase
    s.packet_length = wr_pos;
    s.data_available = avail;
    s.crc_ok = crc_match;
    s.calculated_crc = calc_crc;
    s.received_crc = recv_crc;
    s.read_incomplete = err_latched;
    s.crc_errors = mismatch_cnt;
    return s;
  endfunction

  function automatic string show_status(status_t s);
    return $sformatf({"entry=%02h len=%0d closed=%0b avail=%0b crc_ok=%0b calc=%04h ",
                      "recv=%04h rd_inc=%0b errs=%0d pad=%0h"},
                     s.entry_data, s.packet_length, s.frame_closed, s.data_available,
                     s.crc_ok, s.calculated_crc, s.received_crc, s.read_incomplete,
                     s.crc_errors, s.pad);
  endfunction

  task automatic log_mismatch(string what, status_t got, status_t want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s", $realtime, what);
      $display("  actual:   %s", show_status(got));
      $display("  expected: %s", show_status(want));
    end
  endtask

  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_status.size() == 0) begin
        log_mismatch("result transfer with nothing outstanding", got, '0);
      end else begin
        want = pending_status.pop_front();
        if (got.entry_data !== want.entry_data ||
            got.packet_length !== want.packet_length ||
            got.frame_closed !== want.frame_closed ||
            got.data_available !== want.data_available ||
            got.crc_ok !== want.crc_ok ||
            got.calculated_crc !== want.calculated_crc ||
            got.received_crc !== want.received_crc ||
            got.read_incomplete !== want.read_incomplete ||
            got.crc_errors !== want.crc_errors ||
            got.pad !== want.pad) begin
          log_mismatch("status field mismatch", got, want);
        end
      end
    end
  end

  always @(negedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    case (stall_phase[9:8])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 3) != 0);
      2'd2: out_tready <= stall_pattern[stall_phase[3:0]];
      default: out_tready <= ($urandom_range(0, 1) == 0);
    endcase
  end

  task automatic send_item(op_t op, logic [7:0] data_byte, logic [6:0] index);
    @(negedge clk);
    if (burst_left <= 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {1'b0, index, data_byte};
    do @(posedge clk); while (!in_tready);
    pending_status.push_back(predict_status(op, data_byte, index));
    items_sent++;
    burst_left--;
  endtask

  task automatic send_ticks(int count);
    repeat (count) send_item(OP_TICK, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
  endtask

  task automatic send_frame(logic [7:0] payload[$], bit corrupt);
    logic [15:0] crc;
    crc = '0;
    foreach (payload[i]) begin
      crc = crc16_xmodem(crc, payload[i]);
      send_item(OP_BYTE, payload[i], 7'($urandom_range(0, 127)));
    end
    if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    send_item(OP_BYTE, crc[15:8], 7'($urandom_range(0, 127)));
    send_item(OP_BYTE, crc[7:0], 7'($urandom_range(0, 127)));
  endtask

  task automatic drain_block();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(logic [15:0] value);
    drain_block();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 16'($urandom_range(0, 65535));
    idle_limit = value;
  endtask

  task automatic test_directed_cases();
    logic [7:0] frame[$];
    write_timeout(16'd0);
    send_item(OP_READ, 8'hFF, 7'd0);
    send_item(OP_READ, 8'h00, 7'd127);
    send_item(OP_TICK, 8'hFF, 7'h7F);
    send_item(OP_ACK, 8'h00, 7'd0);
    frame = '{8'hFF, 8'h00};
    send_frame(frame, 1'b0);
    send_item(OP_TICK, 8'h00, 7'd0);
    send_item(OP_READ, 8'h00, 7'd0);
    send_item(OP_READ, 8'h00, 7'd3);
    send_item(OP_ACK, 8'hFF, 7'h7F);
    // A one-byte frame closes as a match; the next close finds no acknowledge.
    send_item(OP_BYTE, 8'hA5, 7'd0);
    send_item(OP_TICK, 8'h00, 7'd0);
    send_item(OP_BYTE, 8'h12, 7'd0);
    send_item(OP_BYTE, 8'h34, 7'd0);
    send_item(OP_BYTE, 8'h56, 7'd0);
    send_item(OP_TICK, 8'h00, 7'd0);
    send_item(OP_BYTE, 8'h80, 7'd0);
    send_item(OP_TICK, 8'h00, 7'd0);
    send_item(OP_ACK, 8'h00, 7'd0);
  endtask

  task automatic test_timeout_extremes();
    write_timeout(16'hFFFF);
    send_item(OP_BYTE, 8'h5A, 7'd0);
    send_ticks(6);
    write_timeout(16'd1);
    send_ticks(2);
    send_item(OP_ACK, 8'h00, 7'd0);
    write_timeout(16'd3);
  endtask

  task automatic test_buffer_wrap();
    logic [7:0] frame[$];
    int i;
    send_item(OP_ACK, 8'h00, 7'd0);
    repeat (DEPTH) begin
      send_item(OP_BYTE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
    end
    send_ticks(idle_limit + 1);
    send_item(OP_READ, 8'h00, 7'd127);
    send_item(OP_READ, 8'h00, 7'd0);
    for (i = 0; i < DEPTH - 3; i++) frame.push_back(8'($urandom_range(0, 255)));
    send_frame(frame, 1'b0);
    send_ticks(idle_limit + 1);
    send_item(OP_READ, 8'h00, 7'd126);
    send_item(OP_READ, 8'h00, 7'd127);
    send_item(OP_ACK, 8'h00, 7'd0);
  endtask

  task automatic test_random_traffic();
    logic [7:0] frame[$];
    int unsigned next_cfg;
    int len;
    int i;
    next_cfg = items_sent + 300;
    while (items_sent < TARGET_ITEMS) begin
      if (items_sent >= next_cfg) begin
        case ($urandom_range(0, 2))
          0: write_timeout(16'd0);
          1: write_timeout(16'd1);
          default: write_timeout(16'($urandom_range(2, 6)));
        endcase
        next_cfg = items_sent + 300;
      end
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 5) != 0) send_item(OP_ACK, 8'($urandom_range(0, 255)), 7'd0);
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, DEPTH - 3)
                                           : $urandom_range(0, 12);
        frame.delete();
        for (i = 0; i < len; i++) frame.push_back(8'($urandom_range(0, 255)));
        send_frame(frame, $urandom_range(0, 4) == 0);
        if ($urandom_range(0, 5) == 0) begin
          send_ticks($urandom_range(0, idle_limit));
          send_item(OP_BYTE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
        end
        send_ticks(idle_limit + 1 + $urandom_range(0, 2));
        repeat ($urandom_range(0, 4)) begin
          send_item(OP_READ, 8'($urandom_range(0, 255)),
                    7'(($urandom_range(0, 1) == 0) ? $urandom_range(0, len + 1)
                                                   : $urandom_range(0, 127)));
        end
        if ($urandom_range(0, 3) != 0) send_item(OP_ACK, 8'($urandom_range(0, 255)), 7'd0);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_item(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    7'($urandom_range(0, 127)));
        end
      end
    end
  endtask

  initial begin
    reset_receiver_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_timeout_extremes();
    test_buffer_wrap();
    test_random_traffic();
    drain_block();
    if (mismatches == 0) begin
      $display("idle_framed_packet_crc_receiver_top regression: pass");
    end else begin
      $display("idle_framed_packet_crc_receiver_top regression: fail");
    end
    $finish;
  end

endmodule

>>> idle_framed_packet_crc_receiver_top.f
+incdir+src
src/ifpcr_pkg.sv
src/ifpcr_store.sv
src/ifpcr_crc.sv
src/idle_framed_packet_crc_receiver_top.sv
sim/tb_idle_framed_packet_crc_receiver_top.sv
